### rtl/core/gdpt_pkg.sv
// Shared constants and types for the greedy distance point thinning block.
// No dependencies; imported by every module in rtl/core.
`timescale 1ns / 1ps

package gdpt_pkg;

	// default sizing, used as defaults by the top level parameters
	localparam int MAX_NODES_DEF  = 256;
	localparam int COORD_BITS_DEF = 16;

	// fixed field widths
	localparam int THR_W = 34;
	localparam int IDX_W = 8;

	// number of coordinate lanes per point
	localparam int AXES = 3;

	// status from the distance pipeline back to the controller
	typedef struct packed {
		logic busy;   // a compare is still in flight
		logic near;   // a stored node lies closer than the threshold
	} dist_status_t;

endpackage

### rtl/core/gdpt_node_mem.sv
// Kept-node store: one write port, one read port with registered read data.
// Depends on gdpt_pkg for the lane count.
`timescale 1ns / 1ps

module gdpt_node_mem #(
	parameter int MAX_NODES  = 256,
	parameter int COORD_BITS = 16,
	localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1,
	localparam int DW = gdpt_pkg::AXES * COORD_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic          rvalid,
	output logic [DW-1:0] rdata
);
	import gdpt_pkg::*;

	logic [DW-1:0] mem_q [MAX_NODES];
	logic [DW-1:0] rdata_s1;
	logic          rvalid_s1;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_s1 <= mem_q[raddr];
		end
	end

	// track which read data is live
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvalid_s1 <= 1'b0;
		end else begin
			rvalid_s1 <= re;
		end
	end

	assign rdata  = rdata_s1;
	assign rvalid = rvalid_s1;

endmodule

### rtl/core/gdpt_dist.sv
// Squared-distance pipeline: difference, square, sum and threshold compare.
// Depends on gdpt_pkg for the status struct and threshold width.
`timescale 1ns / 1ps

module gdpt_dist #(
	parameter int COORD_BITS = 16,
	localparam int PW = gdpt_pkg::AXES * COORD_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      node_valid,
	input  logic [PW-1:0]             node,
	input  logic [PW-1:0]             point,
	input  logic [gdpt_pkg::THR_W-1:0] threshold,
	output gdpt_pkg::dist_status_t    status
);
	import gdpt_pkg::*;

	localparam int DW   = COORD_BITS + 1;
	localparam int SQW  = 2 * DW;
	localparam int SUMW = SQW + 2;
	localparam int CMPW = (SUMW > THR_W) ? SUMW : THR_W;

	logic signed [DW-1:0]  diff_s2 [AXES];
	logic [SQW-1:0]        sq_s3 [AXES];
	logic                  valid_s2;
	logic                  valid_s3;
	logic signed [SQW-1:0] prod [AXES];
	logic [SUMW-1:0]       sum;

	// per-axis difference, sign-extended by one bit so it cannot wrap
	always_ff @(posedge clk) begin
		for (int k = 0; k < AXES; k++) begin
			diff_s2[k] <= $signed({point[k*COORD_BITS + COORD_BITS-1],
			                       point[k*COORD_BITS +: COORD_BITS]})
			            - $signed({node[k*COORD_BITS + COORD_BITS-1],
			                       node[k*COORD_BITS +: COORD_BITS]});
		end
	end

	// square each axis
	always_comb begin
		for (int k = 0; k < AXES; k++) begin
			prod[k] = SQW'(diff_s2[k]) * SQW'(diff_s2[k]);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < AXES; k++) begin
			sq_s3[k] <= $unsigned(prod[k]);
		end
	end

	// advance the valid marks alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s2 <= node_valid;
			valid_s3 <= valid_s2;
		end
	end

	// full-width sum; it never wraps, so no saturation is needed
	assign sum = SUMW'(sq_s3[0]) + SUMW'(sq_s3[1]) + SUMW'(sq_s3[2]);

	assign status.near = valid_s3 && (CMPW'(sum) < CMPW'(threshold));
	assign status.busy = node_valid || valid_s2 || valid_s3;

endmodule

### rtl/core/greedy_distance_point_thinning.sv
// Greedy distance point thinning: keeps a point only if it lies at least the
// configured distance from every node kept so far. Each item passes through an accept
// step, one read per stored node, a drain of the read and the squared-distance
// pipeline, and the write of the verdict; scan and drain are skipped when the store is
// empty or new_set is set. The next item is accepted while a finished result still
// waits on the master side; its own verdict then holds until that result is taken. No
// clearing pass is needed after reset; new_set empties the store at once.
// Depends on gdpt_pkg, gdpt_node_mem and gdpt_dist.
`timescale 1ns / 1ps

module greedy_distance_point_thinning #(
	parameter int MAX_NODES  = gdpt_pkg::MAX_NODES_DEF,
	parameter int COORD_BITS = gdpt_pkg::COORD_BITS_DEF,
	localparam int PW   = gdpt_pkg::AXES * COORD_BITS,
	localparam int IN_W = ((PW + 7) / 8) * 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration
	input  logic                       cfg_we,
	input  logic [gdpt_pkg::THR_W-1:0] cfg_data,    // threshold_sq
	// point stream in
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [IN_W-1:0]            s_tdata,     // pos_x, pos_y, pos_z
	input  logic                       s_tuser,     // new_set
	// verdict stream out
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [15:0]                m_tdata      // kept, node_index[7:0], store_full
);
	import gdpt_pkg::*;

	localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int CW = $clog2(MAX_NODES + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]       state_q;
	logic [THR_W-1:0] threshold_q;
	logic [CW-1:0]    count_q;
	logic [AW-1:0]    rd_idx_q;
	logic [PW-1:0]    pt_q;
	logic             near_q;
	logic             out_valid_q;
	logic             kept_q;
	logic [IDX_W-1:0] index_q;
	logic             full_q;

	logic             accept;
	logic             rd_en;
	logic             rd_last;
	logic             out_free;
	logic             mem_we;
	logic             has_room;
	logic             node_valid;
	logic [PW-1:0]    node_data;
	dist_status_t     dist_st;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign rd_en    = (state_q == ST_SCAN);
	assign rd_last  = (CW'(rd_idx_q) + CW'(1)) == count_q;
	assign out_free = !out_valid_q || m_tready;
	assign has_room = count_q < CW'(MAX_NODES);
	assign mem_we   = (state_q == ST_DONE) && out_free && !near_q && has_room;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= '0;
		end else if (cfg_we) begin
			threshold_q <= cfg_data;
		end
	end

	// hold the point under test
	always_ff @(posedge clk) begin
		if (accept) begin
			pt_q <= s_tdata[PW-1:0];
		end
	end

	// clear on accept, then remember any near hit from the scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_q <= 1'b0;
		end else if (accept) begin
			near_q <= 1'b0;
		end else if (dist_st.near) begin
			near_q <= 1'b1;
		end
	end

	// sequence: accept, scan stored nodes, drain the pipeline, decide
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			rd_idx_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rd_idx_q <= '0;
						if (s_tuser) begin
							count_q <= '0;
						end
						if (s_tuser || count_q == '0) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (rd_last) begin
						state_q <= ST_DRAIN;
					end else begin
						rd_idx_q <= rd_idx_q + AW'(1);
					end
				end
				ST_DRAIN: begin
					if (!dist_st.busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						if (mem_we) begin
							count_q <= count_q + CW'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			kept_q  <= mem_we;
			index_q <= mem_we ? IDX_W'(count_q) : '0;
			full_q  <= !near_q && !has_room;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, full_q, index_q, kept_q};

	gdpt_node_mem #(
		.MAX_NODES (MAX_NODES),
		.COORD_BITS(COORD_BITS)
	) u_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (mem_we),
		.waddr (count_q[AW-1:0]),
		.wdata (pt_q),
		.re    (rd_en),
		.raddr (rd_idx_q),
		.rvalid(node_valid),
		.rdata (node_data)
	);

	gdpt_dist #(
		.COORD_BITS(COORD_BITS)
	) u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.node_valid(node_valid),
		.node      (node_data),
		.point     (pt_q),
		.threshold (threshold_q),
		.status    (dist_st)
	);

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_NODES))
		else $error("node count beyond store size");

	a_kept_xor_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(kept_q && full_q))
		else $error("item both kept and flagged full");

	a_write_idle_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !dist_st.busy)
		else $error("store written while a compare is in flight");

	a_new_set_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser) |=> (count_q == '0))
		else $error("new_set did not empty the store");
`endif

endmodule

### verif/tb_top.sv
// Self-checking bench for greedy_distance_point_thinning: streams 3D points, predicts
// each keep/drop verdict in a behavioral thinning model and checks every returned item.
// Depends on gdpt_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps

module tb_top;

	import gdpt_pkg::*;

	localparam int MAX_NODES     = MAX_NODES_DEF;
	localparam int RAND_ITEMS    = 1100;
	localparam int STALL_LIMIT   = 20000;
	localparam int REPORT_LINES  = 30;

	localparam logic [THR_W-1:0] SPACING_MAX = '1;
	// squared span from corner to corner of the coordinate cube
	localparam logic [THR_W-1:0] CUBE_DIAG_SQ = 34'd12884508675;

	typedef struct packed {
		logic             kept;
		logic [IDX_W-1:0] node_index;
		logic             store_full;
	} verdict_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [THR_W-1:0]  cfg_data = '0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [47:0]       s_tdata = '0;     // pos_x, pos_y, pos_z
	logic              s_tuser = 1'b0;   // new_set
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [15:0]       m_tdata;          // kept, node_index[7:0], store_full

	// thinning model state
	logic signed [15:0] node_x [MAX_NODES];
	logic signed [15:0] node_y [MAX_NODES];
	logic signed [15:0] node_z [MAX_NODES];
	int                 node_count = 0;
	logic [THR_W-1:0]   spacing_sq = '0;

	verdict_t verdict_q [$];
	bit       idle_en = 1'b1;
	int       errors = 0;
	int       points_sent = 0;
	int       verdicts_seen = 0;
	int       n_kept = 0;
	int       n_thinned = 0;
	int       n_full = 0;
	int       idle_cycles = 0;

	greedy_distance_point_thinning i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Thin one point against the kept nodes and return its verdict.
	function automatic verdict_t thin_predict(logic signed [15:0] px, logic signed [15:0] py,
			logic signed [15:0] pz, logic fresh);
		verdict_t   v;
		longint     dx, dy, dz;
		logic [63:0] sum_sq;
		bit         near;
		near = 1'b0;
		v = '0;
		if (fresh) begin
			node_count = 0;
		end
		for (int i = 0; i < node_count; i++) begin
			dx = longint'(px) - longint'(node_x[i]);
			dy = longint'(py) - longint'(node_y[i]);
			dz = longint'(pz) - longint'(node_z[i]);
			sum_sq = dx * dx + dy * dy + dz * dz;
			if (sum_sq < {30'b0, spacing_sq}) begin
				near = 1'b1;
				break;
			end
		end
		if (near) begin
			n_thinned++;
		end else if (node_count < MAX_NODES) begin
			node_x[node_count] = px;
			node_y[node_count] = py;
			node_z[node_count] = pz;
			v.kept = 1'b1;
			v.node_index = node_count[IDX_W-1:0];
			node_count++;
			n_kept++;
		end else begin
			v.store_full = 1'b1;
			n_full++;
		end
		return v;
	endfunction

	task automatic report_mismatch(string field, longint got, longint want);
		if (errors < REPORT_LINES) begin
			$display("mismatch at verdict %0d: %s got %0d, expected %0d",
				verdicts_seen, field, got, want);
		end
		errors++;
	endtask

	// Compare one returned item with the oldest expected verdict.
	task automatic check_verdict(logic [15:0] word);
		verdict_t want;
		if (verdict_q.size() == 0) begin
			report_mismatch("unexpected item", longint'(word), longint'(0));
		end else begin
			want = verdict_q.pop_front();
			if (word[0] !== want.kept)
				report_mismatch("kept", longint'(word[0]), longint'(want.kept));
			if (word[8:1] !== want.node_index)
				report_mismatch("node_index", longint'(word[8:1]),
					longint'(want.node_index));
			if (word[9] !== want.store_full)
				report_mismatch("store_full", longint'(word[9]),
					longint'(want.store_full));
			if (word[15:10] !== 6'b0)
				report_mismatch("padding", longint'(word[15:10]), longint'(0));
		end
		verdicts_seen++;
	endtask

	// Offer one point, hold it until accepted, and queue its verdict.
	task automatic send_point(logic signed [15:0] px, logic signed [15:0] py,
			logic signed [15:0] pz, logic fresh);
		int       gap;
		verdict_t want;
		gap = idle_en ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {pz, py, px};
		s_tuser  <= fresh;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		want = thin_predict(px, py, pz, fresh);
		verdict_q.insert(verdict_q.size(), want);
		points_sent++;
	endtask

	// Stop offering and wait until every verdict is back.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_spacing(logic [THR_W-1:0] value);
		drain();
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we   <= 1'b0;
		spacing_sq = value;
	endtask

	// Corners, duplicates, and thresholds right at the distance.
	task automatic test_extremes();
		write_spacing('0);
		send_point(16'sd0, 16'sd0, 16'sd0, 1'b1);
		send_point(-16'sd32768, -16'sd32768, -16'sd32768, 1'b0);
		send_point(16'sd32767, 16'sd32767, 16'sd32767, 1'b0);
		send_point(16'sd0, 16'sd0, 16'sd0, 1'b0);
		send_point(-16'sd1, -16'sd1, -16'sd1, 1'b0);
		write_spacing(SPACING_MAX);
		send_point(-16'sd32768, -16'sd32768, -16'sd32768, 1'b1);
		send_point(16'sd32767, 16'sd32767, 16'sd32767, 1'b0);
		send_point(16'sd32767, -16'sd32768, 16'sd32767, 1'b0);
		// distance equal to threshold passes
		write_spacing(CUBE_DIAG_SQ);
		send_point(-16'sd32768, -16'sd32768, -16'sd32768, 1'b1);
		send_point(16'sd32767, 16'sd32767, 16'sd32767, 1'b0);
		// one above fails
		write_spacing(CUBE_DIAG_SQ + 34'd1);
		send_point(-16'sd32768, -16'sd32768, -16'sd32768, 1'b1);
		send_point(16'sd32767, 16'sd32767, 16'sd32767, 1'b0);
		write_spacing(34'd1);
		send_point(16'sd100, -16'sd200, 16'sd300, 1'b1);
		send_point(16'sd100, -16'sd200, 16'sd300, 1'b0);
		send_point(16'sd101, -16'sd200, 16'sd300, 1'b0);
		send_point(16'sd100, -16'sd200, 16'sd300, 1'b0);
		send_point(16'sh5555, 16'shAAAA, 16'sh5555, 1'b0);
		send_point(16'shAAAA, 16'sh5555, 16'shAAAA, 1'b0);
	endtask

	// Fill the store at zero spacing, overflow it, then clear it.
	task automatic test_store_full();
		write_spacing('0);
		for (int k = 0; k < MAX_NODES + 4; k++) begin
			send_point(16'($urandom), 16'($urandom), 16'($urandom), k == 0);
		end
		send_point(16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
		send_point(16'($urandom), 16'($urandom), 16'($urandom), 1'b0);
	endtask

	// Phases of random clouds, each with its own spacing and idling mode.
	task automatic test_random_sets();
		int               sent, n, shape, r, cx, cy, cz;
		logic [63:0]      wide;
		logic [THR_W-1:0] thr;
		logic             fresh;
		logic [15:0]      px, py, pz;
		sent = 0;
		while (sent < RAND_ITEMS) begin
			idle_en = ($urandom_range(0, 3) != 0);
			shape = $urandom_range(0, 2);
			r = $urandom_range(1, 2047);
			cx = int'($urandom_range(0, 65535)) - 32768;
			cy = int'($urandom_range(0, 65535)) - 32768;
			cz = int'($urandom_range(0, 65535)) - 32768;
			if (shape == 0) begin
				wide = {$urandom, $urandom};
				case ($urandom_range(0, 4))
					0: thr = '0;
					1: thr = SPACING_MAX;
					2: thr = wide[THR_W-1:0];
					default: thr = 34'($urandom >> $urandom_range(0, 31));
				endcase
			end else begin
				thr = 34'($urandom_range(0, 3 * r * r));
			end
			write_spacing(thr);
			n = $urandom_range(40, 120);
			for (int k = 0; k < n; k++) begin
				fresh = (k == 0) || ($urandom_range(0, 29) == 0);
				if (shape == 0) begin
					px = 16'($urandom);
					py = 16'($urandom);
					pz = 16'($urandom);
				end else begin
					// wraps at the cube edge, which is still a legal point
					px = 16'(cx + int'($urandom_range(0, 2 * r)) - r);
					py = 16'(cy + int'($urandom_range(0, 2 * r)) - r);
					pz = 16'(cz + int'($urandom_range(0, 2 * r)) - r);
				end
				send_point(px, py, pz, fresh);
				sent++;
			end
		end
		idle_en = 1'b1;
	endtask

	// Accept verdict items with random back-pressure.
	initial begin : verdict_sink
		int stall;
		@(posedge arst_n);
		forever begin
			stall = idle_en ? $urandom_range(0, 10) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			check_verdict(m_tdata);
		end
	end

	// End the run if neither side moves an item for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin : run_tests
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_store_full();
		test_random_sets();
		drain();
		repeat (MAX_NODES + 10) @(posedge clk);
		if (verdict_q.size() != 0) begin
			report_mismatch("verdicts never returned", longint'(verdict_q.size()),
				longint'(0));
		end
		$display("covered %0d points: %0d kept, %0d thinned, %0d refused on a full store",
			points_sent, n_kept, n_thinned, n_full);
		$display("%0d verdicts checked, %0d mismatches", verdicts_seen, errors);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
